@@ design/slr_pkg.sv @@
// Shared types and constants of the stereo linear resampler.
`default_nettype none

package slr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int STEP_W        = 17;
  localparam int FRAC_BITS_DEF = 16;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  localparam logic              BYPASS_RESET = 1'b1;
  localparam logic [STEP_W-1:0] STEP_RESET   = 17'd65536;

  // Register index taken from the word address of the config port.
  typedef enum logic [0:0] {
    REG_BYPASS = 1'b0,
    REG_STEP   = 1'b1
  } slr_reg_idx_t;

  // Live configuration, plus a pulse on any register write.
  typedef struct packed {
    logic              bypass;
    logic [STEP_W-1:0] step;
    logic              clr;
  } slr_cfg_t;

  // Pending result: the two frames to blend and its end-of-run flag.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cur_l;
    logic signed [SAMPLE_W-1:0] cur_r;
    logic signed [SAMPLE_W-1:0] prev_l;
    logic signed [SAMPLE_W-1:0] prev_r;
    logic                       last;
  } slr_job_t;

endpackage

`default_nettype wire

@@ design/slr_if.sv @@
// Valid/ready channel interfaces for input frames and result frames.
`default_nettype none

interface slr_in_if
  import slr_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       block_end;

  modport src (output valid, left_sample, right_sample, block_end, input ready);
  modport snk (input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface slr_out_if
  import slr_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last_of_run;

  modport src (output valid, left_out, right_out, last_of_run, input ready);
  modport snk (input valid, left_out, right_out, last_of_run, output ready);
endinterface

`default_nettype wire

@@ design/slr_cfg.sv @@
// APB register file: bypass and phase step, with a clear pulse on every write.
`default_nettype none

module slr_cfg
  import slr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output slr_cfg_t                   cfg
);

  logic              bypass_r;
  logic [STEP_W-1:0] step_r;
  logic              wr;
  slr_reg_idx_t      idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = slr_reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= BYPASS_RESET;
      step_r   <= STEP_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_BYPASS: bypass_r <= pwdata[0];
        REG_STEP:   step_r   <= pwdata[STEP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BYPASS: prdata = {{(APB_DATA_W-1){1'b0}}, bypass_r};
      REG_STEP:   prdata = {{(APB_DATA_W-STEP_W){1'b0}}, step_r};
      default:    prdata = '0;
    endcase
  end

  // Any write restarts the converter, as a rate change does.
  assign cfg.bypass = bypass_r;
  assign cfg.step   = step_r;
  assign cfg.clr    = wr;

endmodule

`default_nettype wire

@@ design/slr_front.sv @@
// Phase accumulator, previous-frame state and the pending-result register.
`default_nettype none

module slr_front
  import slr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire slr_cfg_t                   cfg,
  input  wire logic                       in_valid,
  input  wire logic signed [SAMPLE_W-1:0] in_left,
  input  wire logic signed [SAMPLE_W-1:0] in_right,
  output logic                            in_ready,
  input  wire logic                       job_take,
  output logic                            job_v,
  output slr_job_t                        job,
  output logic [FRAC_BITS-1:0]            job_frac
);

  localparam int PH_W  = (FRAC_BITS + 1 > STEP_W) ? FRAC_BITS + 1 : STEP_W;
  localparam int SUM_W = PH_W + 2;

  logic [PH_W-1:0]            phase_r, phase_nxt;
  logic signed [SAMPLE_W-1:0] prev_l_r, prev_rt_r;
  logic                       have_prev_r;
  logic                       job_v_r, job_two_r;
  logic signed [SAMPLE_W-1:0] job_cur_l_r, job_cur_r_r, job_prev_l_r, job_prev_r_r;
  logic [FRAC_BITS-1:0]       frac_r, frac2_r;

  logic [SUM_W-1:0] one_q, min_step, step_ext, step_eff, ph0, ph1, ph2, ph_end;
  logic             has1, has2, in_fire;

  assign one_q    = SUM_W'(1) << FRAC_BITS;
  assign min_step = SUM_W'(1) << (FRAC_BITS - 1);
  assign step_ext = SUM_W'(cfg.step);
  assign step_eff = (step_ext < min_step) ? min_step : step_ext;

  assign ph0  = SUM_W'(phase_r);
  assign ph1  = ph0 + step_eff;
  assign ph2  = ph1 + step_eff;
  assign has1 = ph0 < one_q;
  assign has2 = has1 && (ph1 < one_q);

  always_comb begin
    priority if (!has1) begin
      ph_end = ph0;
    end else if (!has2) begin
      ph_end = ph1;
    end else begin
      ph_end = ph2;
    end
  end

  assign phase_nxt = PH_W'(ph_end - one_q);

  // Take a new frame once the last pending result moves to the output stage.
  assign in_ready = !job_v_r || (job_take && !job_two_r);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      have_prev_r <= 1'b0;
      prev_l_r    <= '0;
      prev_rt_r   <= '0;
      job_v_r     <= 1'b0;
      job_two_r   <= 1'b0;
    end else begin
      if (cfg.clr) begin
        phase_r     <= '0;
        have_prev_r <= 1'b0;
        prev_l_r    <= '0;
        prev_rt_r   <= '0;
      end else if (in_fire && !cfg.bypass) begin
        phase_r     <= phase_nxt;
        have_prev_r <= 1'b1;
        prev_l_r    <= in_left;
        prev_rt_r   <= in_right;
      end

      if (in_fire) begin
        job_v_r   <= cfg.bypass || has1;
        job_two_r <= !cfg.bypass && has2;
      end else if (job_take) begin
        if (job_two_r) begin
          job_two_r <= 1'b0;
        end else begin
          job_v_r <= 1'b0;
        end
      end
    end
  end

  // Bypass blends the frame with itself at zero phase, which returns it unchanged.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_cur_l_r  <= in_left;
      job_cur_r_r  <= in_right;
      job_prev_l_r <= (cfg.bypass || !have_prev_r) ? in_left  : prev_l_r;
      job_prev_r_r <= (cfg.bypass || !have_prev_r) ? in_right : prev_rt_r;
      frac_r       <= cfg.bypass ? '0 : ph0[FRAC_BITS-1:0];
      frac2_r      <= ph1[FRAC_BITS-1:0];
    end else if (job_take && job_two_r) begin
      frac_r <= frac2_r;
    end
  end

  assign job_v       = job_v_r;
  assign job.cur_l   = job_cur_l_r;
  assign job.cur_r   = job_cur_r_r;
  assign job.prev_l  = job_prev_l_r;
  assign job.prev_r  = job_prev_r_r;
  assign job.last    = !job_two_r;
  assign job_frac    = frac_r;

`ifndef SYNTHESIS
  a_clr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.clr |=> (phase_r == '0) && !have_prev_r)
    else $error("state not cleared after register write");

  a_seed_prev: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg.bypass && !cfg.clr |=> have_prev_r)
    else $error("previous frame not seeded");

  a_bypass_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cfg.bypass && !cfg.clr |=> phase_r == $past(phase_r))
    else $error("bypass frame moved the phase");

  a_two_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_two_r |-> job_v_r)
    else $error("second result pending without a job");
`endif

endmodule

`default_nettype wire

@@ design/slr_emit.sv @@
// Interpolator and output register: one result beat per cycle while the output is not stalled.
`default_nettype none

module slr_emit
  import slr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_v,
  input  wire slr_job_t             job,
  input  wire logic [FRAC_BITS-1:0] job_frac,
  output logic                      job_take,
  slr_out_if.src                    out_ch
);

  logic                       out_v_r;
  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic                       last_r;
  logic                       out_load;

  // prev + floor((cur - prev) * frac / 2^FRAC_BITS), exact at full width
  function automatic logic [SAMPLE_W-1:0] lerp(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRAC_BITS-1:0]       f
  );
    logic signed [SAMPLE_W:0]             d;
    logic signed [SAMPLE_W+FRAC_BITS+1:0] p;
    logic signed [SAMPLE_W:0]             q;
    logic [SAMPLE_W:0]                    s;
    d = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
    p = d * $signed({1'b0, f});
    q = p[SAMPLE_W+FRAC_BITS:FRAC_BITS];
    s = {a[SAMPLE_W-1], a} + q;
    return s[SAMPLE_W-1:0];
  endfunction

  assign out_load = !out_v_r || out_ch.ready;
  assign job_take = job_v && out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= job_v;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      left_r  <= lerp(job.prev_l, job.cur_l, job_frac);
      right_r <= lerp(job.prev_r, job.cur_r, job_frac);
      last_r  <= job.last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.left_out    = left_r;
  assign out_ch.right_out   = right_r;
  assign out_ch.last_of_run = last_r;

endmodule

`default_nettype wire

@@ design/stereo_linear_resampler.sv @@
// Top level of the stereo linear-interpolation sample rate converter.
//
//   Port group   Dir  Handshake              Beat payload
//   in_ch        in   valid / ready          left_sample, right_sample, block_end
//   out_ch       out  valid / ready          left_out, right_out, last_of_run
//   APB          in   psel, penable, pwrite  paddr, pwdata (prdata on read)
//
// A frame causes zero, one or two results (one in bypass).
// The single interpolator feeding the output register limits intake; an input
// frame with two results holds the pending stage until both are taken.
// The first result passes the pending register and then the output register.
// Synchronous active-low reset; bypass on, step 1.0, phase and history cleared.
// A stalled output holds its beat while the next frame is already taken in.
`default_nettype none

module stereo_linear_resampler
  import slr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  slr_in_if.snk                      in_ch,
  slr_out_if.src                     out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  slr_cfg_t             cfg;
  slr_job_t             job;
  logic                 job_v;
  logic                 job_take;
  logic [FRAC_BITS-1:0] job_frac;

  slr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_left  (in_ch.left_sample),
    .in_right (in_ch.right_sample),
    .in_ready (in_ch.ready),
    .job_take (job_take),
    .job_v    (job_v),
    .job      (job),
    .job_frac (job_frac)
  );

  slr_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_v    (job_v),
    .job      (job),
    .job_frac (job_frac),
    .job_take (job_take),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the stereo linear resampler: predicts every output frame and checks it.
`timescale 1ns / 100ps

module tb_top;
  import slr_pkg::*;

  class interp_checker;
    typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
    } out_frame_t;

    out_frame_t                 due_frames[$];
    bit                         bypass_on;
    bit          [STEP_W-1:0]   step;
    longint                     phase;
    logic signed [SAMPLE_W-1:0] hist_l;
    logic signed [SAMPLE_W-1:0] hist_r;
    bit                         primed;
    int                         mismatches;

    function new();
      bypass_on  = BYPASS_RESET;
      step       = STEP_RESET;
      mismatches = 0;
      clear_history();
    endfunction

    function void clear_history();
      phase  = 0;
      hist_l = '0;
      hist_r = '0;
      primed = 1'b0;
    endfunction

    function void write_reg(slr_reg_idx_t idx, logic [APB_DATA_W-1:0] val);
      case (idx)
        REG_BYPASS: bypass_on = val[0];
        REG_STEP:   step = val[STEP_W-1:0];
        default: ;
      endcase
      clear_history();
    endfunction

    // Floor of (b - a) * frac / 2^FRAC_BITS, added to a.
    function logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                              logic signed [SAMPLE_W-1:0] b,
                                              longint frac);
      longint diff;
      longint delta;
      diff  = longint'(b) - longint'(a);
      delta = (diff * frac) >>> FRAC_BITS_DEF;
      return SAMPLE_W'(longint'(a) + delta);
    endfunction

    function void take_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      longint     one;
      longint     eff;
      longint     ph;
      int         n;
      out_frame_t f;
      one = longint'(1) << FRAC_BITS_DEF;
      if (bypass_on) begin
        f.left  = l;
        f.right = r;
        f.last  = 1'b1;
        due_frames.push_back(f);
        return;
      end
      eff = (longint'(step) < one / 2) ? one / 2 : longint'(step);
      if (!primed) begin
        hist_l = l;
        hist_r = r;
        primed = 1'b1;
      end
      ph = phase;
      n  = 0;
      while (ph < one && n < 2) begin
        f.left  = blend(hist_l, l, ph);
        f.right = blend(hist_r, r, ph);
        f.last  = (n == 1) || (ph + eff >= one);
        due_frames.push_back(f);
        n++;
        ph += eff;
      end
      phase  = (ph - one) & 'h1FFFF;
      hist_l = l;
      hist_r = r;
    endfunction

    function void check_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                              logic last);
      out_frame_t f;
      if (due_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected frame L %0d R %0d last %0b", $realtime, l, r, last);
        return;
      end
      f = due_frames.pop_front();
      if (l !== f.left || r !== f.right || last !== f.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: frame mismatch: expected L %0d R %0d last %0b, got L %0d R %0d last %0b",
                   $realtime, f.left, f.right, f.last, l, r, last);
      end
    endfunction

    function int pending();
      return due_frames.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    send_idle_pct;
  int                    recv_stall_pct;

  slr_in_if  in_if();
  slr_out_if out_if();

  interp_checker sb = new();

  stereo_linear_resampler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    out_if.ready   = 1'b0;
    recv_stall_pct = 0;
    send_idle_pct  = 0;
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_frame(out_if.left_out, out_if.right_out, out_if.last_of_run);
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic set_idling(int mode);
    case (mode)
      1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
      3:       begin send_idle_pct = 15; recv_stall_pct = 15; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic apb_write(slr_reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(int'(idx) * 4);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                            logic be);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid        = 1'b1;
    in_if.left_sample  = l;
    in_if.right_sample = r;
    in_if.block_end    = be;
    do @(posedge clk); while (!in_if.ready);
    sb.take_frame(l, r);
  endtask

  // Drop valid and hold until every predicted frame is out, then let the pipe empty.
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return ($urandom_range(0, 1) != 0) ? 16'sh0000 : 16'shFFFF;
      3:       return SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [STEP_W-1:0] rate;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.left_sample  = '0;
    in_if.right_sample = '0;
    in_if.block_end    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // bypass out of reset
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(16'sh0000, 16'shFFFF, 1'b0);
    settle();

    // step 1.0: first frame seeds history, then each output is the previous frame
    apb_write(REG_BYPASS, 32'd0);
    send_frame(16'sd100, -16'sd100, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(16'shFFFF, 16'sh0000, 1'b0);
    send_frame(16'sh5555, 16'shAAAA, 1'b0);
    settle();

    // half step: two outputs per frame, midpoint rounds toward minus infinity
    apb_write(REG_STEP, 32'd32768);
    send_frame(16'sh8000, 16'sh7FFF, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sd12345, -16'sd12345, 1'b1);
    send_frame(-16'sd7, 16'sd7, 1'b0);
    settle();

    // largest step: some frames produce nothing
    apb_write(REG_STEP, 32'd131071);
    send_frame(16'sd1000, -16'sd1000, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(-16'sd3, 16'sd3, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(16'sd55, -16'sd55, 1'b0);
    settle();

    // zero step is clamped to half
    apb_write(REG_STEP, 32'd0);
    send_frame(16'sd1, -16'sd1, 1'b0);
    send_frame(-16'sd2, 16'sd2, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1:       rate = 17'd71330;
        2:       rate = 17'd60211;
        3:       rate = 17'd32768;
        4:       rate = 17'd131071;
        5:       rate = STEP_W'($urandom_range(0, 32767));
        7:       rate = 17'd65536;
        default: rate = STEP_W'($urandom);
      endcase
      apb_write(REG_STEP, 32'(rate));
      apb_write(REG_BYPASS, (ph == 0 || ph == 6) ? 32'd1 : 32'd0);
      set_idling(ph % 4);
      for (int k = 0; k < 82; k++) begin
        if (ph == 2 && k == 40)
          settle();
        send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
      end
      set_idling(0);
      settle();
    end

    if (sb.pending() != 0)
      $display("%0d predicted frames never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/slr_pkg.sv
design/slr_if.sv
design/slr_cfg.sv
design/slr_front.sv
design/slr_emit.sv
design/stereo_linear_resampler.sv
dv/tb_top.sv
